/* rtl/pcent_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcent_pkg: polygon centroid shared definitions
// Field widths, accumulator widths, status codes and channel payload types.
// ----------------------------------------------------------------------------
package pcent_pkg;

	localparam int COORD_W    = 16;
	localparam int CNT_W      = 8;
	localparam int CROSS_W    = 48;
	localparam int MOM_W      = 64;
	localparam int MAX_VERTICES_DEF = 128;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FEW  = 2'd1,
		ST_ZERO = 2'd2,
		ST_MANY = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		status_t                   status;
	} result_t;

endpackage
`default_nettype wire

/* rtl/polygon_centroid_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_centroid_top: shoelace polygon centroid in Q4.12
// Vertices enter one per transaction on the vertex channel; last_vertex marks
// the final one. A single result transaction per polygon leaves on the result
// channel with the centroid, saturated, and a status code.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low. vertex_stall is high whenever the sequencer is busy.
// Sequencing, all on one shared signed multiplier and one restoring divider:
//   first vertex, or a dropped vertex: stored or dropped, no products
//   any other vertex: 8 sequencer steps, six products per edge
//   final vertex after an earlier one: its own edge and the closing edge, then
//   two 64-step divisions (none for FEW or ZERO); then the result is registered
// After the final vertex all accumulation state is cleared for the next
// polygon. The result sits in an output register; a stalled receiver only
// holds the sequencer when a new result is ready and the old one is unread.
// Reset (arst_n low) clears all state and drops any pending result.
// ----------------------------------------------------------------------------
module polygon_centroid_top
	import pcent_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    vertex_valid,
	output logic         vertex_stall,
	input  wire vertex_t vertex,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	localparam int CW     = COORD_W;
	localparam int MA_W   = CW + 1;
	localparam int MB_W   = CW + 2;
	localparam int PROD_W = MA_W + MB_W;
	localparam int C_W    = 2 * CW + 1;
	localparam int L_W    = CW + 1;
	localparam int DEN_W  = CROSS_W + 2;
	localparam int REM_W  = DEN_W + 1;
	localparam int DCNT_W = $clog2(MOM_W);
	localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_VERTICES);
	localparam logic [CNT_W-1:0]  MIN_CNT  = CNT_W'(3);
	localparam logic [DCNT_W-1:0] DCNT_END = DCNT_W'(MOM_W - 1);
	localparam logic [MOM_W-1:0]  Q_HI     = MOM_W'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic [MOM_W-1:0]  Q_NLIM   = Q_HI + MOM_W'(1);
	localparam logic [CW-1:0]     SAT_HI   = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0]     SAT_LO   = {1'b1, {(CW-1){1'b0}}};

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000_0000_0000_0001,
		S_CA     = 16'b0000_0000_0000_0010,
		S_CB     = 16'b0000_0000_0000_0100,
		S_CC     = 16'b0000_0000_0000_1000,
		S_XL     = 16'b0000_0000_0001_0000,
		S_XH     = 16'b0000_0000_0010_0000,
		S_YL     = 16'b0000_0000_0100_0000,
		S_YH     = 16'b0000_0000_1000_0000,
		S_FIN    = 16'b0000_0001_0000_0000,
		S_CLOSE  = 16'b0000_0010_0000_0000,
		S_CHECK  = 16'b0000_0100_0000_0000,
		S_TRIPLE = 16'b0000_1000_0000_0000,
		S_LOAD   = 16'b0001_0000_0000_0000,
		S_DIV    = 16'b0010_0000_0000_0000,
		S_SAT    = 16'b0100_0000_0000_0000,
		S_OUT    = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [CW-1:0] ex0_q, ey0_q, ex1_q, ey1_q;
	logic [CNT_W-1:0]     count_q;
	logic                 overflow_q, last_q, closed_q, div_y_q;
	logic [CROSS_W-1:0]   cross_q;
	logic [MOM_W-1:0]     mx_q, my_q;
	logic signed [PROD_W-1:0] prod_q, tmp_q;
	logic [C_W-1:0]       c_q;
	logic [DEN_W-1:0]     den_q;
	logic                 den_neg_q, num_neg_q;
	logic [MOM_W-1:0]     dq_q;
	logic [REM_W-1:0]     rem_q;
	logic [DCNT_W-1:0]    dcnt_q;
	logic [CW-1:0]        cx_q, cy_q;
	status_t              st_q;
	result_t              result_q;
	logic                 result_valid_q;

	logic signed [MA_W-1:0]   sx, sy, mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic signed [PROD_W-1:0] prod_d, pdiff;
	logic [MOM_W-1:0]         c64, p64, p64_hi, num_sel;
	logic [DEN_W-1:0]         cross_ext;
	logic [REM_W-1:0]         rem_sh;
	logic [REM_W:0]           rem_diff;
	logic                     rem_ge;
	logic [CW-1:0]            q_low, sat_val;
	logic                     accept;

	assign sx = $signed({ex0_q[CW-1], ex0_q}) + $signed({ex1_q[CW-1], ex1_q});
	assign sy = $signed({ey0_q[CW-1], ey0_q}) + $signed({ey1_q[CW-1], ey1_q});

	always_comb begin
		case (state_q)
			S_CA: begin
				mul_a = $signed({ex0_q[CW-1], ex0_q});
				mul_b = $signed({{2{ey1_q[CW-1]}}, ey1_q});
			end
			S_CB: begin
				mul_a = $signed({ex1_q[CW-1], ex1_q});
				mul_b = $signed({{2{ey0_q[CW-1]}}, ey0_q});
			end
			S_XL: begin
				mul_a = sx;
				mul_b = $signed({1'b0, c_q[L_W-1:0]});
			end
			S_XH: begin
				mul_a = sx;
				mul_b = $signed({{2{c_q[C_W-1]}}, c_q[C_W-1:L_W]});
			end
			S_YL: begin
				mul_a = sy;
				mul_b = $signed({1'b0, c_q[L_W-1:0]});
			end
			S_YH: begin
				mul_a = sy;
				mul_b = $signed({{2{c_q[C_W-1]}}, c_q[C_W-1:L_W]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;
	assign pdiff  = tmp_q - prod_q;
	assign c64    = {{(MOM_W-C_W){c_q[C_W-1]}}, c_q};
	assign p64    = {{(MOM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign p64_hi = p64 << L_W;

	// divider datapath
	assign cross_ext = {{2{cross_q[CROSS_W-1]}}, cross_q};
	assign num_sel   = div_y_q ? my_q : mx_q;
	assign rem_sh    = {rem_q[REM_W-2:0], dq_q[MOM_W-1]};
	assign rem_diff  = {1'b0, rem_sh} - {2'b00, den_q};
	assign rem_ge    = !rem_diff[REM_W];

	// saturation of the quotient magnitude
	assign q_low = dq_q[CW-1:0];
	always_comb begin
		if (num_neg_q ^ den_neg_q) begin
			sat_val = (dq_q > Q_NLIM) ? SAT_LO : CW'(~q_low + 1'b1);
		end else begin
			sat_val = (dq_q > Q_HI) ? SAT_HI : q_low;
		end
	end

	assign accept       = vertex_valid && (state_q == S_IDLE);
	assign vertex_stall = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_x_q      <= '0;
			first_y_q      <= '0;
			prev_x_q       <= '0;
			prev_y_q       <= '0;
			ex0_q          <= '0;
			ey0_q          <= '0;
			ex1_q          <= '0;
			ey1_q          <= '0;
			count_q        <= '0;
			overflow_q     <= 1'b0;
			last_q         <= 1'b0;
			closed_q       <= 1'b0;
			div_y_q        <= 1'b0;
			cross_q        <= '0;
			mx_q           <= '0;
			my_q           <= '0;
			prod_q         <= '0;
			tmp_q          <= '0;
			c_q            <= '0;
			den_q          <= '0;
			den_neg_q      <= 1'b0;
			num_neg_q      <= 1'b0;
			dq_q           <= '0;
			rem_q          <= '0;
			dcnt_q         <= '0;
			cx_q           <= '0;
			cy_q           <= '0;
			st_q           <= ST_OK;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != S_OUT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q   <= vertex.last_vertex;
						closed_q <= 1'b0;
						if (count_q >= MAX_CNT) begin
							overflow_q <= 1'b1;
							state_q    <= vertex.last_vertex ? S_CLOSE : S_IDLE;
						end else if (count_q == '0) begin
							first_x_q <= vertex.vertex_x;
							first_y_q <= vertex.vertex_y;
							prev_x_q  <= vertex.vertex_x;
							prev_y_q  <= vertex.vertex_y;
							count_q   <= count_q + 1'b1;
							state_q   <= vertex.last_vertex ? S_CLOSE : S_IDLE;
						end else begin
							ex0_q    <= prev_x_q;
							ey0_q    <= prev_y_q;
							ex1_q    <= vertex.vertex_x;
							ey1_q    <= vertex.vertex_y;
							prev_x_q <= vertex.vertex_x;
							prev_y_q <= vertex.vertex_y;
							count_q  <= count_q + 1'b1;
							state_q  <= S_CA;
						end
					end
				end
				S_CA: begin
					prod_q  <= prod_d;
					state_q <= S_CB;
				end
				S_CB: begin
					tmp_q   <= prod_q;
					prod_q  <= prod_d;
					state_q <= S_CC;
				end
				S_CC: begin
					c_q     <= pdiff[C_W-1:0];
					state_q <= S_XL;
				end
				S_XL: begin
					prod_q  <= prod_d;
					cross_q <= cross_q + c64[CROSS_W-1:0];
					state_q <= S_XH;
				end
				S_XH: begin
					prod_q  <= prod_d;
					mx_q    <= mx_q + p64;
					state_q <= S_YL;
				end
				S_YL: begin
					prod_q  <= prod_d;
					mx_q    <= mx_q + p64_hi;
					state_q <= S_YH;
				end
				S_YH: begin
					prod_q  <= prod_d;
					my_q    <= my_q + p64;
					state_q <= S_FIN;
				end
				S_FIN: begin
					my_q    <= my_q + p64_hi;
					state_q <= last_q ? S_CLOSE : S_IDLE;
				end
				S_CLOSE: begin
					// closing edge from the previous vertex back to the first
					if ((count_q != '0) && !closed_q) begin
						ex0_q    <= prev_x_q;
						ey0_q    <= prev_y_q;
						ex1_q    <= first_x_q;
						ey1_q    <= first_y_q;
						closed_q <= 1'b1;
						state_q  <= S_CA;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cx_q      <= '0;
					cy_q      <= '0;
					div_y_q   <= 1'b0;
					den_neg_q <= cross_q[CROSS_W-1];
					den_q     <= cross_q[CROSS_W-1] ? (~cross_ext + 1'b1) : cross_ext;
					if (count_q < MIN_CNT) begin
						st_q    <= ST_FEW;
						state_q <= S_OUT;
					end else if (cross_q == '0) begin
						st_q    <= ST_ZERO;
						state_q <= S_OUT;
					end else begin
						st_q    <= overflow_q ? ST_MANY : ST_OK;
						state_q <= S_TRIPLE;
					end
				end
				S_TRIPLE: begin
					den_q   <= den_q + {den_q[DEN_W-2:0], 1'b0};
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					num_neg_q <= num_sel[MOM_W-1];
					dq_q      <= num_sel[MOM_W-1] ? (~num_sel + 1'b1) : num_sel;
					rem_q     <= '0;
					dcnt_q    <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= rem_ge ? rem_diff[REM_W-1:0] : rem_sh;
					dq_q   <= {dq_q[MOM_W-2:0], rem_ge};
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_END) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					if (div_y_q) begin
						cy_q    <= sat_val;
						state_q <= S_OUT;
					end else begin
						cx_q    <= sat_val;
						div_y_q <= 1'b1;
						state_q <= S_LOAD;
					end
				end
				S_OUT: begin
					if (!result_valid_q || !result_stall) begin
						result_q.centroid_x <= cx_q;
						result_q.centroid_y <= cy_q;
						result_q.status     <= st_q;
						result_valid_q      <= 1'b1;
						// clear for the next polygon
						first_x_q  <= '0;
						first_y_q  <= '0;
						prev_x_q   <= '0;
						prev_y_q   <= '0;
						count_q    <= '0;
						overflow_q <= 1'b0;
						last_q     <= 1'b0;
						closed_q   <= 1'b0;
						div_y_q    <= 1'b0;
						cross_q    <= '0;
						mx_q       <= '0;
						my_q       <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
